/* src/mwf_pkg.sv */
package mwf_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FACTOR_W = 8;

  // Largest n whose factorial is computed; anything above gets an error result.
  localparam logic [WORD_W-1:0]   FACT_LIMIT   = 32'd170;
  localparam logic [FACTOR_W-1:0] FIRST_FACTOR = 8'd2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_ERR   = 5'b10000
  } state_t;

  typedef struct packed {
    logic                init;
    logic                shift;
    logic                inj_valid;
    logic [FACTOR_W-1:0] inj_factor;
  } cell_ctrl_t;

endpackage

/* src/mwf_if.sv */
interface mwf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] n_value;

  modport source (output valid, output n_value, input ready);
  modport sink   (input valid, input n_value, output ready);
endinterface

interface mwf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;
  logic        last_word;
  logic        too_large;

  modport source (output valid, output result_word, output last_word, output too_large,
                  input ready);
  modport sink   (input valid, input result_word, input last_word, input too_large,
                  output ready);
endinterface

/* src/mwf_cell.sv */
module mwf_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mwf_pkg::cell_ctrl_t           ctrl,
  input  logic                          init_lsb,
  input  logic [mwf_pkg::WORD_W-1:0]    upper_word,
  input  logic                          mul_valid_i,
  input  logic [mwf_pkg::FACTOR_W-1:0]  factor_i,
  input  logic [mwf_pkg::FACTOR_W-1:0]  carry_i,
  output logic [mwf_pkg::WORD_W-1:0]    word_o,
  output logic                          mul_valid_o,
  output logic [mwf_pkg::FACTOR_W-1:0]  factor_o,
  output logic [mwf_pkg::FACTOR_W-1:0]  carry_o
);

  localparam int unsigned PROD_W = mwf_pkg::WORD_W + mwf_pkg::FACTOR_W;

  logic [mwf_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic                         valid_r;
  logic [mwf_pkg::FACTOR_W-1:0] factor_r;
  logic [mwf_pkg::FACTOR_W-1:0] carry_r;
  logic [PROD_W-1:0]            prod;

  // The factor is below 256 and so is the incoming carry, so the sum fits in 40 bits.
  assign prod = {{mwf_pkg::FACTOR_W{1'b0}}, word_r} * {{mwf_pkg::WORD_W{1'b0}}, factor_i}
              + {{mwf_pkg::WORD_W{1'b0}}, carry_i};

  always_comb begin
    word_nxt = word_r;
    if (ctrl.init) begin
      word_nxt = {{(mwf_pkg::WORD_W-1){1'b0}}, init_lsb};
    end else if (ctrl.shift) begin
      word_nxt = upper_word;
    end else if (mul_valid_i) begin
      word_nxt = prod[mwf_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (mul_valid_i) begin
      factor_r <= factor_i;
      carry_r  <= prod[PROD_W-1:mwf_pkg::WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= mul_valid_i;
    end
  end

  assign word_o      = word_r;
  assign mul_valid_o = valid_r;
  assign factor_o    = factor_r;
  assign carry_o     = carry_r;

endmodule

/* src/mwf_ctrl.sv */
module mwf_ctrl #(
  parameter int WORDS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mwf_pkg::WORD_W-1:0]  n_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        last_word,
  output logic                        too_large,
  output mwf_pkg::cell_ctrl_t         ctrl
);

  localparam int unsigned CNT_W = $clog2(WORDS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORDS - 1);

  mwf_pkg::state_t              state_r, state_nxt;
  logic [mwf_pkg::FACTOR_W-1:0] n_r, n_nxt;
  logic [mwf_pkg::FACTOR_W-1:0] factor_r, factor_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;

  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    factor_nxt      = factor_r;
    cnt_nxt         = cnt_r;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    last_word       = 1'b0;
    too_large       = 1'b0;
    ctrl.init       = 1'b0;
    ctrl.shift      = 1'b0;
    ctrl.inj_valid  = 1'b0;
    ctrl.inj_factor = factor_r;
    case (state_r)
      mwf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (n_value > mwf_pkg::FACT_LIMIT) begin
            state_nxt = mwf_pkg::ST_ERR;
          end else begin
            ctrl.init  = 1'b1;
            n_nxt      = n_value[mwf_pkg::FACTOR_W-1:0];
            factor_nxt = mwf_pkg::FIRST_FACTOR;
            state_nxt  = mwf_pkg::ST_MUL;
          end
        end
      end
      mwf_pkg::ST_MUL: begin
        // One pass enters the chain per cycle; earlier passes are still moving up.
        if (factor_r <= n_r) begin
          ctrl.inj_valid = 1'b1;
          factor_nxt     = factor_r + 1'b1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = mwf_pkg::ST_DRAIN;
        end
      end
      mwf_pkg::ST_DRAIN: begin
        // Wait until the last pass has reached the top word.
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = mwf_pkg::ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      mwf_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        last_word = (cnt_r == CNT_LAST);
        if (out_ready) begin
          ctrl.shift = 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_nxt = mwf_pkg::ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      mwf_pkg::ST_ERR: begin
        out_valid = 1'b1;
        last_word = 1'b1;
        too_large = 1'b1;
        if (out_ready) begin
          state_nxt = mwf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mwf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwf_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    factor_r <= factor_nxt;
  end

endmodule

/* src/multiword_factorial.sv */
// Channel   Direction  Handshake     Payload
// in_if     sink       valid/ready   n_value[31:0]
// out_if    source     valid/ready   result_word[31:0], last_word, too_large
//
// A request with n up to 170 is computed in two phases: one pass per factor
// 2..n enters a chain of WORDS word cells in turn, and a drain phase then lets
// the last pass reach the top cell. Each cell has its own 32x8 multiplier. WORDS
// results then follow, one per accepted output cycle. A request above 170 gives
// its single error result on the next cycle.
// Reset (rst_n low, synchronous) returns the controller to idle; no clearing pass.
// Output stalls freeze the word chain; in_if.ready is high only while idle.
module multiword_factorial #(
  parameter int WORDS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  mwf_in_if.sink   in_if,
  mwf_out_if.source out_if
);

  mwf_pkg::cell_ctrl_t          ctrl;
  logic                         too_large;
  logic [mwf_pkg::WORD_W-1:0]   word   [WORDS];
  logic                         valid  [WORDS];
  logic [mwf_pkg::FACTOR_W-1:0] factor [WORDS];
  logic [mwf_pkg::FACTOR_W-1:0] carry  [WORDS];

  mwf_ctrl #(.WORDS(WORDS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .n_value   (in_if.n_value),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .last_word (out_if.last_word),
    .too_large (too_large),
    .ctrl      (ctrl)
  );

  for (genvar k = 0; k < WORDS; k++) begin : g_cell
    logic                         mul_valid_in;
    logic [mwf_pkg::FACTOR_W-1:0] factor_in;
    logic [mwf_pkg::FACTOR_W-1:0] carry_in;
    logic [mwf_pkg::WORD_W-1:0]   upper;

    if (k == 0) begin : g_first
      assign mul_valid_in = ctrl.inj_valid;
      assign factor_in    = ctrl.inj_factor;
      assign carry_in     = '0;
    end else begin : g_rest
      assign mul_valid_in = valid[k-1];
      assign factor_in    = factor[k-1];
      assign carry_in     = carry[k-1];
    end

    // During output the words move down one cell per accepted result.
    if (k == WORDS - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = word[k+1];
    end

    mwf_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .init_lsb    (k == 0),
      .upper_word  (upper),
      .mul_valid_i (mul_valid_in),
      .factor_i    (factor_in),
      .carry_i     (carry_in),
      .word_o      (word[k]),
      .mul_valid_o (valid[k]),
      .factor_o    (factor[k]),
      .carry_o     (carry[k])
    );
  end

  assign out_if.too_large   = too_large;
  assign out_if.result_word = too_large ? '0 : word[0];

endmodule

/* src/mwf_checker.sv */
module mwf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] n_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_word,
  input logic        last_word,
  input logic        too_large
);

  // An error result is a single, last word of zero.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && too_large |-> last_word && (result_word == 32'd0))
    else $error("error result is not a single zero word");

  // A request above the limit is answered on the next cycle with an error.
  a_err_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (n_value > 32'd170) |=> out_valid && too_large)
    else $error("oversized request did not give an error result");

  // The block takes no request while a result is on offer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("request accepted while results are pending");

  // A run of words continues without a gap until its last word.
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_word |=> out_valid && !too_large)
    else $error("word run broken before its last word");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_word) && $stable(last_word)
      && $stable(too_large))
    else $error("stalled result changed");

endmodule

bind multiword_factorial mwf_checker u_mwf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .n_value     (in_if.n_value),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .result_word (out_if.result_word),
  .last_word   (out_if.last_word),
  .too_large   (out_if.too_large)
);
